[sv/quaternion_vector_rotate_defines.svh]
// Assertion macros for the quaternion vector rotation block.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QVR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion_vector_rotate: property violated");

// next-cycle implication, disabled in reset
`define QVR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion_vector_rotate: property violated");

`endif

[sv/qvr_pkg.sv]
// Shared types, widths, latencies and tables for the quaternion vector rotation block.
`default_nettype none
package qvr_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 34;   // CORDIC datapath width
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   localparam int VW    = 32;          // vector component width
   localparam int AW    = 16;          // axis component width
   localparam int WW    = 17;          // versor scalar part, Q.15
   localparam int BW    = 18;          // versor vector part, Q.15
   localparam int PW    = 33;          // sin * axis product
   localparam int MW    = 36;          // norm and matrix numerators
   localparam int RFRAC = 28;
   localparam int QW    = RFRAC + 1;   // quotient magnitude bits
   localparam int RW    = RFRAC + 2;   // signed matrix entry, Q.28
   localparam int XW    = 62;          // entry * component
   localparam int ACW   = 64;          // row accumulator

   localparam int CORDIC_LAT = CORDIC_STEPS + 1;
   localparam int MAT_LAT    = 5;
   localparam int DIV_LAT    = QW + 2;
   localparam int MAC_LAT    = 3;
   localparam int TOTAL_LAT  = CORDIC_LAT + MAT_LAT + DIV_LAT + MAC_LAT;

   typedef struct packed {
      logic signed [VW-1:0] vec_x;
      logic signed [VW-1:0] vec_y;
      logic signed [VW-1:0] vec_z;
      logic signed [AW-1:0] axis_x;
      logic signed [AW-1:0] axis_y;
      logic signed [AW-1:0] axis_z;
      logic [15:0]          angle;
   } req_type;

   typedef struct packed {
      logic signed [VW-1:0] rot_x;
      logic signed [VW-1:0] rot_y;
      logic signed [VW-1:0] rot_z;
      logic                 saturated;
      logic                 degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [AW-1:0] x;
      logic signed [AW-1:0] y;
      logic signed [AW-1:0] z;
   } axis_type;

   typedef struct packed {
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] s;
   } sincos_type;

   typedef struct packed {
      logic [MW-1:0]          n;
      logic [8:0][MW-1:0]     m;   // row-major, entry i*3+j
      logic                   deg;
   } mat_type;

   typedef logic [8:0][RW-1:0] rmat_type;

endpackage
`default_nettype wire

[sv/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotation pipeline.
// An accepted request runs through the CORDIC, versor/matrix, divider and
//   multiply/round stages, in that order, to its rsp_valid strobe.
// Throughput: one request per cycle; busy stays low, the result side cannot stall.
// Reset: synchronous, clears every valid bit; requests in flight are dropped.
// The 9-way pipelined divider (one quotient bit per stage) sets the depth.
`default_nettype none
`include "quaternion_vector_rotate_defines.svh"
module quaternion_vector_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qvr_pkg::req_type req_data,
   output logic             rsp_valid,
   output qvr_pkg::rsp_type rsp_data
);
   import qvr_pkg::*;

   localparam int VEC_LAT = CORDIC_LAT + MAT_LAT + DIV_LAT;

   logic       accept;
   logic       cor_vld, mat_vld, div_vld;
   sincos_type cor_sc;
   mat_type    mat;
   rmat_type   rmat;

   // side-band delay lines so the vector and axis meet the math stage that uses them
   axis_type axis_dly_in;
   vec_type  vec_dly_in;
   axis_type axis_dly_ff [0:CORDIC_LAT-1];
   vec_type  vec_dly_ff  [0:VEC_LAT-1];
   logic     deg_dly_ff  [0:DIV_LAT-1];

   // the pipeline takes a request every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign axis_dly_in = '{x: req_data.axis_x, y: req_data.axis_y, z: req_data.axis_z};
   assign vec_dly_in  = '{x: req_data.vec_x,  y: req_data.vec_y,  z: req_data.vec_z};

   always_ff @(posedge clock) begin
      axis_dly_ff[0] <= axis_dly_in;
      for (int k = 1; k < CORDIC_LAT; k++) axis_dly_ff[k] <= axis_dly_ff[k-1];
      vec_dly_ff[0] <= vec_dly_in;
      for (int k = 1; k < VEC_LAT; k++) vec_dly_ff[k] <= vec_dly_ff[k-1];
      deg_dly_ff[0] <= mat.deg;
      for (int k = 1; k < DIV_LAT; k++) deg_dly_ff[k] <= deg_dly_ff[k-1];
   end

   // half-angle sine and cosine
   qvr_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (accept),
      .angle   (req_data.angle),
      .out_vld (cor_vld),
      .out_sc  (cor_sc)
   );

   // versor, norm and matrix numerators
   qvr_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (cor_vld),
      .in_sc   (cor_sc),
      .in_axis (axis_dly_ff[CORDIC_LAT-1]),
      .out_vld (mat_vld),
      .out_mat (mat)
   );

   // normalize every entry by the squared norm; entry 0 carries the valid
   for (genvar e = 0; e < 9; e++) begin : g_div
      if (e == 0) begin : g_lead
         qvr_divider u_div (
            .clock   (clock),
            .reset   (reset),
            .in_vld  (mat_vld),
            .num     (mat.m[e]),
            .den     (mat.n),
            .out_vld (div_vld),
            .quo     (rmat[e])
         );
      end else begin : g_rest
         qvr_divider u_div (
            .clock   (clock),
            .reset   (reset),
            .in_vld  (mat_vld),
            .num     (mat.m[e]),
            .den     (mat.n),
            .out_vld (),
            .quo     (rmat[e])
         );
      end
   end

   // rotate the vector, round and saturate
   qvr_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (div_vld),
      .in_r    (rmat),
      .in_vec  (vec_dly_ff[VEC_LAT-1]),
      .in_deg  (deg_dly_ff[DIV_LAT-1]),
      .out_vld (rsp_valid),
      .out_rsp (rsp_data)
   );

   // a degenerate versor forces an all-zero, unsaturated result
   `QVR_ASSERT_IMP(a_deg_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.rot_x == '0 && rsp_data.rot_y == '0 && rsp_data.rot_z == '0 && !rsp_data.saturated)

   // a saturated result has at least one component pinned at a bound
   `QVR_ASSERT_IMP(a_sat_bound, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.rot_x == 32'sh7FFFFFFF || rsp_data.rot_x == 32'sh80000000 || rsp_data.rot_y == 32'sh7FFFFFFF || rsp_data.rot_y == 32'sh80000000 || rsp_data.rot_z == 32'sh7FFFFFFF || rsp_data.rot_z == 32'sh80000000)

   // a divider output always leads to a strobe after the multiply/round stages
   `QVR_ASSERT_IMP(a_vld_align, clock, reset, div_vld, ##MAC_LAT rsp_valid)

endmodule
`default_nettype wire

[sv/qvr_cordic.sv]
// Pipelined rotation CORDIC: half-angle phase to cosine and sine in Q2.30.
`default_nettype none
module qvr_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [15:0]         angle,
   output logic                out_vld,
   output qvr_pkg::sincos_type out_sc
);
   import qvr_pkg::*;

   localparam int SH = 31 - ANGLE_BITS;

   logic [39:0] ang_wide;
   logic [31:0] phase;

   logic signed [CW-1:0] x_in  [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_in  [0:CORDIC_STEPS];
   logic signed [CW-1:0] z_in  [0:CORDIC_STEPS];
   logic signed [CW-1:0] x_ff  [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff  [0:CORDIC_STEPS];
   logic signed [CW-1:0] z_ff  [0:CORDIC_STEPS];
   logic                 vld_ff [0:CORDIC_STEPS];

   assign ang_wide = 40'(angle) & ((40'd1 << ANGLE_BITS) - 40'd1);
   assign phase    = 32'(ang_wide << SH);

   // quarter-turn pre-rotation; phase < 2^31 so the residue is the low 30 bits
   assign x_in[0] = phase[30] ? '0 : CORDIC_GAIN;
   assign y_in[0] = phase[30] ? CORDIC_GAIN : '0;
   assign z_in[0] = CW'(phase[29:0]);

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = CW'(ATAN_TURNS[i]);
      assign x_in[i+1] = z_ff[i][CW-1] ? x_ff[i] + dx : x_ff[i] - dx;
      assign y_in[i+1] = z_ff[i][CW-1] ? y_ff[i] - dy : y_ff[i] + dy;
      assign z_in[i+1] = z_ff[i][CW-1] ? z_ff[i] + at : z_ff[i] - at;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
         z_ff[k] <= z_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k <= CORDIC_STEPS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign out_vld  = vld_ff[CORDIC_STEPS];
   assign out_sc.c = x_ff[CORDIC_STEPS];
   assign out_sc.s = y_ff[CORDIC_STEPS];

endmodule
`default_nettype wire

[sv/qvr_matrix.sv]
// Versor quantization, squared norm and rotation-matrix numerators, five stages.
`default_nettype none
module qvr_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  qvr_pkg::sincos_type in_sc,
   input  qvr_pkg::axis_type   in_axis,
   output logic                out_vld,
   output qvr_pkg::mat_type    out_mat
);
   import qvr_pkg::*;

   logic [MAT_LAT-1:0] vld_ff;

   // stage 1: round to Q.15
   logic signed [WW-1:0] w1_in, w1_ff, s1_in, s1_ff;
   axis_type             ax1_ff;
   // stage 2: sin times axis
   logic signed [PW-1:0] px_in, py_in, pz_in, px_ff, py_ff, pz_ff;
   logic signed [WW-1:0] w2_ff;
   // stage 3: round to Q.15
   logic signed [BW-1:0] bx_in, by_in, bz_in, bx_ff, by_ff, bz_ff;
   logic signed [WW-1:0] w3_ff;
   // stage 4: products
   logic signed [MW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [MW-1:0] wx_ff, wy_ff, wz_ff;
   // stage 5: sums
   mat_type              mat_in, mat_ff;

   assign w1_in = WW'((in_sc.c + CW'(34'sd16384)) >>> 15);
   assign s1_in = WW'((in_sc.s + CW'(34'sd16384)) >>> 15);

   assign px_in = s1_ff * ax1_ff.x;
   assign py_in = s1_ff * ax1_ff.y;
   assign pz_in = s1_ff * ax1_ff.z;

   assign bx_in = BW'((px_ff + PW'(33'sd8192)) >>> 14);
   assign by_in = BW'((py_ff + PW'(33'sd8192)) >>> 14);
   assign bz_in = BW'((pz_ff + PW'(33'sd8192)) >>> 14);

   always_comb begin
      mat_in.n    = MW'(ww_ff + xx_ff + yy_ff + zz_ff);
      mat_in.m[0] = MW'(ww_ff + xx_ff - yy_ff - zz_ff);
      mat_in.m[4] = MW'(ww_ff - xx_ff + yy_ff - zz_ff);
      mat_in.m[8] = MW'(ww_ff - xx_ff - yy_ff + zz_ff);
      mat_in.m[1] = MW'((xy_ff - wz_ff) <<< 1);
      mat_in.m[3] = MW'((xy_ff + wz_ff) <<< 1);
      mat_in.m[2] = MW'((xz_ff + wy_ff) <<< 1);
      mat_in.m[6] = MW'((xz_ff - wy_ff) <<< 1);
      mat_in.m[5] = MW'((yz_ff - wx_ff) <<< 1);
      mat_in.m[7] = MW'((yz_ff + wx_ff) <<< 1);
      // norm is zero only when every square is zero
      mat_in.deg  = (ww_ff == '0) && (xx_ff == '0) && (yy_ff == '0) && (zz_ff == '0);
   end

   always_ff @(posedge clock) begin
      w1_ff  <= w1_in;
      s1_ff  <= s1_in;
      ax1_ff <= in_axis;
      px_ff  <= px_in;
      py_ff  <= py_in;
      pz_ff  <= pz_in;
      w2_ff  <= w1_ff;
      bx_ff  <= bx_in;
      by_ff  <= by_in;
      bz_ff  <= bz_in;
      w3_ff  <= w2_ff;
      ww_ff  <= w3_ff * w3_ff;
      xx_ff  <= bx_ff * bx_ff;
      yy_ff  <= by_ff * by_ff;
      zz_ff  <= bz_ff * bz_ff;
      xy_ff  <= bx_ff * by_ff;
      xz_ff  <= bx_ff * bz_ff;
      yz_ff  <= by_ff * bz_ff;
      wx_ff  <= w3_ff * bx_ff;
      wy_ff  <= w3_ff * by_ff;
      wz_ff  <= w3_ff * bz_ff;
      mat_ff <= mat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[MAT_LAT-2:0], in_vld};
      end
   end

   assign out_vld = vld_ff[MAT_LAT-1];
   assign out_mat = mat_ff;

endmodule
`default_nettype wire

[sv/qvr_divider.sv]
// Pipelined restoring divider: round(num * 2^28 / den), ties away from zero.
`default_nettype none
module qvr_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [qvr_pkg::MW-1:0]  num,
   input  logic [qvr_pkg::MW-1:0]  den,
   output logic                    out_vld,
   output logic [qvr_pkg::RW-1:0]  quo
);
   import qvr_pkg::*;

   logic [MW-1:0] r_in   [0:QW];
   logic [QW-1:0] q_in   [0:QW];
   logic [MW-1:0] r_ff   [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [MW-1:0] den_ff [0:QW];
   logic          neg_ff [0:QW];
   logic          vld_ff [0:QW];

   logic [MW-1:0] half;
   logic          up;
   logic [RW-1:0] mag;
   logic [RW-1:0] quo_in, quo_ff;
   logic          ovld_ff;

   // |num| <= den, so the first quotient bit is the 2^28 place
   assign r_in[0] = num[MW-1] ? MW'(-num) : num;
   assign q_in[0] = '0;

   for (genvar s = 0; s < QW; s++) begin : g_bit
      logic [MW-1:0] t;
      logic          b;
      if (s == 0) begin : g_first
         assign t = r_ff[s];
      end else begin : g_next
         assign t = {r_ff[s][MW-2:0], 1'b0};
      end
      assign b         = t >= den_ff[s];
      assign r_in[s+1] = b ? t - den_ff[s] : t;
      assign q_in[s+1] = {q_ff[s][QW-2:0], b};
   end

   assign half   = den_ff[QW] >> 1;
   assign up     = (r_ff[QW] + half) >= den_ff[QW];
   assign mag    = RW'(q_ff[QW]) + RW'(up);
   assign quo_in = neg_ff[QW] ? RW'(-mag) : mag;

   always_ff @(posedge clock) begin
      den_ff[0] <= den;
      neg_ff[0] <= num[MW-1];
      for (int k = 0; k <= QW; k++) begin
         r_ff[k] <= r_in[k];
         q_ff[k] <= q_in[k];
      end
      for (int k = 1; k <= QW; k++) begin
         den_ff[k] <= den_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) vld_ff[k] <= 1'b0;
         ovld_ff <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k <= QW; k++) vld_ff[k] <= vld_ff[k-1];
         ovld_ff <= vld_ff[QW];
      end
   end

   assign out_vld = ovld_ff;
   assign quo     = quo_ff;

endmodule
`default_nettype wire

[sv/qvr_mac.sv]
// Matrix times vector, rounding from Q.28 and saturation to 32 bits.
`default_nettype none
module qvr_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  qvr_pkg::rmat_type   in_r,
   input  qvr_pkg::vec_type    in_vec,
   input  logic                in_deg,
   output logic                out_vld,
   output qvr_pkg::rsp_type    out_rsp
);
   import qvr_pkg::*;

   logic [MAC_LAT-1:0]    vld_ff;
   logic signed [VW-1:0]  v [3];
   logic signed [XW-1:0]  prod_in [9];
   logic signed [XW-1:0]  prod_ff [9];
   logic signed [ACW-1:0] acc_in  [3];
   logic signed [ACW-1:0] acc_ff  [3];
   logic                  deg1_ff, deg2_ff;
   logic signed [VW-1:0]  rot [3];
   logic [2:0]            clip;
   rsp_type               rsp_in, rsp_ff;

   assign v[0] = in_vec.x;
   assign v[1] = in_vec.y;
   assign v[2] = in_vec.z;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         prod_in[k] = $signed(in_r[k]) * v[k % 3];
      end
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = ACW'(prod_ff[3*i]) + ACW'(prod_ff[3*i+1]) + ACW'(prod_ff[3*i+2]);
      end
   end

   always_comb begin
      logic signed [ACW-1:0] t;
      for (int i = 0; i < 3; i++) begin
         t = (acc_ff[i] + 64'sd134217728) >>> RFRAC;
         if (t > 64'sd2147483647) begin
            rot[i]  = 32'sh7FFFFFFF;
            clip[i] = 1'b1;
         end else if (t < -64'sd2147483648) begin
            rot[i]  = 32'sh80000000;
            clip[i] = 1'b1;
         end else begin
            rot[i]  = t[VW-1:0];
            clip[i] = 1'b0;
         end
      end
      if (deg2_ff) begin
         rsp_in = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.rot_x      = rot[0];
         rsp_in.rot_y      = rot[1];
         rsp_in.rot_z      = rot[2];
         rsp_in.saturated  = |clip;
         rsp_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) prod_ff[k] <= prod_in[k];
      for (int i = 0; i < 3; i++) acc_ff[i] <= acc_in[i];
      deg1_ff <= in_deg;
      deg2_ff <= deg1_ff;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[MAC_LAT-2:0], in_vld};
      end
   end

   assign out_vld = vld_ff[MAC_LAT-1];
   assign out_rsp = rsp_ff;

endmodule
`default_nettype wire

[bench/tb_quaternion_vector_rotate.sv]
// Self-checking testbench for the quaternion vector rotation pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_quaternion_vector_rotate;
   import qvr_pkg::*;

   localparam int LATENCY     = 70;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [63:0] INT32_HI = 64'sd2147483647;
   localparam logic signed [63:0] INT32_LO = -64'sd2147483648;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type rotation_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      allow_idle  = 1'b1;

   always #5 clock = ~clock;

   quaternion_vector_rotate dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // round(v / 2^s), ties toward +inf: adds half, then >>> on a signed 64-bit value floors
   function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // 30-step rotation CORDIC on the half-angle phase; returns cos and sin in Q2.30
   function automatic void cordic_sincos(logic [31:0] phase,
                                         output logic signed [63:0] c,
                                         output logic signed [63:0] s);
      logic signed [63:0] x, y, z, dx, dy;
      x = CORDIC_GAIN;
      y = 0;
      z = {32'd0, phase};
      if (z >= (64'sd1 <<< 30)) begin
         x = 0;
         y = CORDIC_GAIN;
         z = z - (64'sd1 <<< 30);
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - $signed({32'd0, ATAN_TURNS[i]});
         end else begin
            x = x + dx; y = y - dy; z = z + $signed({32'd0, ATAN_TURNS[i]});
         end
      end
      c = x;
      s = y;
   endfunction

   // matrix numerator over the norm in Q.28, nearest with ties away from zero
   function automatic logic signed [63:0] scaled_ratio(logic signed [63:0] num,
                                                       logic signed [63:0] n);
      logic [63:0] mag, q;
      mag = (num < 0 ? -num : num);
      mag = mag << RFRAC;
      q   = (mag + n / 2) / n;
      return num < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic rsp_type predict_rotation(req_type r);
      rsp_type            res;
      logic signed [63:0] c, s, w, s15, n, acc, val;
      logic signed [63:0] v[3], u[3], b[3], m[3][3];
      logic [39:0]        ang;
      logic [31:0]        phase;
      ang   = 40'(r.angle) & ((40'd1 << ANGLE_BITS) - 40'd1);
      phase = 32'(ang << (31 - ANGLE_BITS));
      v[0] = r.vec_x;  v[1] = r.vec_y;  v[2] = r.vec_z;
      u[0] = r.axis_x; u[1] = r.axis_y; u[2] = r.axis_z;
      cordic_sincos(phase, c, s);
      w   = round_shift(c, 15);
      s15 = round_shift(s, 15);
      for (int i = 0; i < 3; i++) b[i] = round_shift(s15 * u[i], 14);
      n = w*w + b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      res = '0;
      if (n == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      m[0][0] = w*w + b[0]*b[0] - b[1]*b[1] - b[2]*b[2];
      m[1][1] = w*w - b[0]*b[0] + b[1]*b[1] - b[2]*b[2];
      m[2][2] = w*w - b[0]*b[0] - b[1]*b[1] + b[2]*b[2];
      m[0][1] = 2 * (b[0]*b[1] - w*b[2]);
      m[1][0] = 2 * (b[0]*b[1] + w*b[2]);
      m[0][2] = 2 * (b[0]*b[2] + w*b[1]);
      m[2][0] = 2 * (b[0]*b[2] - w*b[1]);
      m[1][2] = 2 * (b[1]*b[2] - w*b[0]);
      m[2][1] = 2 * (b[1]*b[2] + w*b[0]);
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += scaled_ratio(m[i][j], n) * v[j];
         val = round_shift(acc, RFRAC);
         if (val > INT32_HI) begin
            val = INT32_HI; res.saturated = 1'b1;
         end else if (val < INT32_LO) begin
            val = INT32_LO; res.saturated = 1'b1;
         end
         case (i)
            0: res.rot_x = val[31:0];
            1: res.rot_y = val[31:0];
            default: res.rot_z = val[31:0];
         endcase
      end
      return res;
   endfunction

   // idle bursts, about a quarter of the time
   task automatic maybe_idle();
      if (allow_idle && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
   endtask

   // drive one request and hold it until the block takes it
   task automatic send_request(req_type r);
      maybe_idle();
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      rotation_queue.push_back(predict_rotation(r));
   endtask

   task automatic finish_requests();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_request(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] az, logic [15:0] ang);
      req_type r;
      r.vec_x = x;  r.vec_y = y;  r.vec_z = z;
      r.axis_x = ax; r.axis_y = ay; r.axis_z = az;
      r.angle = ang;
      return r;
   endfunction

   function automatic logic [31:0] random_component();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(32'hFFFF) - 32'h8000;
      endcase
   endfunction

   function automatic logic [15:0] random_axis_component();
      case ($urandom_range(2))
         0: return 16'($urandom);
         1: return 16'($urandom_range(16'h4000) - 16'h2000);
         default: return 16'h0000;
      endcase
   endfunction

   // extremes of each field, unit axes, degenerate versors, zero axis at zero angle, saturation
   task automatic test_directed();
      send_request(make_request(32'h0001_0000, 0, 0, 16'h4000, 0, 0, 16'h0000));
      send_request(make_request(32'h0001_0000, 0, 0, 0, 0, 16'h4000, 16'h4000));
      send_request(make_request(0, 32'h0001_0000, 0, 16'h4000, 0, 0, 16'h8000));
      send_request(make_request(0, 0, 32'h0001_0000, 0, 16'h4000, 0, 16'hC000));
      send_request(make_request(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                                0, 0, 16'h4000, 16'hFFFF));
      // degenerate: at a half-turn angle the cosine of the half angle is zero and the axis is null
      send_request(make_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0,
                                16'h8000));
      send_request(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                0, 0, 0, 16'h8000));
      // null axis, angle zero: identity
      send_request(make_request(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0));
      // saturation: a large vector turned toward a full axis
      send_request(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 16'h4000, 16'h2000));
      send_request(make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                16'h4000, 16'h4000, 16'h4000, 16'h2AAA));
      send_request(make_request(32'h8000_0000, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF,
                                16'h5555));
      send_request(make_request(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                                16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
      send_request(make_request(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                16'h0001, 16'hFFFF, 16'h0001, 16'h7FFF));
      send_request(make_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                                16'h5555, 16'hAAAA, 16'h00FF, 16'hAAAA));
   endtask

   task automatic test_random(int count);
      for (int k = 0; k < count; k++)
         send_request(make_request(random_component(), random_component(),
                                   random_component(), random_axis_component(),
                                   random_axis_component(), random_axis_component(),
                                   16'($urandom)));
   endtask

   // results come as one-cycle strobes; compare each against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (rotation_queue.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            error_count++;
         end else begin
            want = rotation_queue.pop_front();
            if (rsp_data.rot_x !== want.rot_x) begin
               $error("rot_x expected %h actual %h", want.rot_x, rsp_data.rot_x);
               error_count++;
            end
            if (rsp_data.rot_y !== want.rot_y) begin
               $error("rot_y expected %h actual %h", want.rot_y, rsp_data.rot_y);
               error_count++;
            end
            if (rsp_data.rot_z !== want.rot_z) begin
               $error("rot_z expected %h actual %h", want.rot_z, rsp_data.rot_z);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %b actual %b", want.saturated,
                      rsp_data.saturated);
               error_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate expected %b actual %b", want.degenerate,
                      rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      // closing stretch at full rate, back to back
      allow_idle = 1'b0;
      test_random(100);
      finish_requests();
      while (rotation_queue.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (error_count == 0 && rotation_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

[quaternion_vector_rotate.f]
+incdir+sv
sv/qvr_pkg.sv
sv/qvr_cordic.sv
sv/qvr_matrix.sv
sv/qvr_divider.sv
sv/qvr_mac.sv
sv/quaternion_vector_rotate.sv
bench/tb_quaternion_vector_rotate.sv
